/* hdl/battery_voltage_gauge_defines.svh */
// ----------------------------------------------------------------------------
// Battery voltage gauge assertion macros
// Concurrent assertion helpers used by the gauge controller. They are empty when
// SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BATTERY_VOLTAGE_GAUGE_DEFINES_SVH
`define BATTERY_VOLTAGE_GAUGE_DEFINES_SVH

`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define BVG_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Condition that must never be true outside reset.
`define BVG_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);
`else
`define BVG_ASSERT(label, clk, rst_n, prop, msg)
`define BVG_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

/* hdl/bvg_pkg.sv */
// ----------------------------------------------------------------------------
// Battery voltage gauge package
// Widths, constants and the controller to datapath command types.
// ----------------------------------------------------------------------------
package bvg_pkg;

    localparam int SAMPLES_DEFAULT = 16;

    localparam int SAMPLE_W = 12;
    localparam int RES_W    = 24;
    localparam int MV_W     = 16;
    localparam int PCT_W    = 7;
    localparam int IDX_W    = 2;

    // Shared divider: numerator/quotient width and divisor width.
    localparam int DIV_N     = 40;
    localparam int DEN_W     = RES_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_N);

    localparam logic [SAMPLE_W-1:0] ADC_FULL_SCALE_MV = 12'd3300;
    localparam logic [SAMPLE_W-1:0] ADC_MAX_CODE      = 12'd4095;
    localparam logic [MV_W-1:0]     MV_LIMIT          = 16'd65535;
    localparam logic [PCT_W-1:0]    PCT_FULL          = 7'd100;
    localparam logic [PCT_W-1:0]    PCT_EMPTY         = 7'd0;

    // The pin voltage is avg * 3300 / 4095. The product stays below 2^24, so
    // a rounded-up reciprocal of 4095 with a 36-bit shift gives the exact floor.
    localparam int PIN_NUM_W = 2 * SAMPLE_W;
    localparam int PIN_SH    = PIN_NUM_W + SAMPLE_W;
    localparam int PIN_MUL_W = PIN_NUM_W + 1;
    localparam logic [PIN_MUL_W-1:0] PIN_MUL =
        PIN_MUL_W'(((64'd1 << PIN_SH) + 64'(ADC_MAX_CODE) - 64'd1) / 64'(ADC_MAX_CODE));

    localparam logic [RES_W-1:0] UPPER_R_RESET  = 24'd100000;
    localparam logic [RES_W-1:0] LOWER_R_RESET  = 24'd100000;
    localparam logic [MV_W-1:0]  FULL_MV_RESET  = 16'd4200;
    localparam logic [MV_W-1:0]  EMPTY_MV_RESET = 16'd3000;

    typedef enum logic [IDX_W-1:0] {
        REG_UPPER_R,
        REG_LOWER_R,
        REG_FULL_MV,
        REG_EMPTY_MV
    } t_cfg_reg;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCUM,
        OP_LAST,
        OP_AVG,
        OP_DIV,
        OP_LOAD_PIN,
        OP_PIN,
        OP_RSUM,
        OP_LOAD_SCALE,
        OP_VOLT,
        OP_LOAD_PCT,
        OP_PUBLISH
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic pct_trivial;
    } t_dp_status;

endpackage

/* hdl/bvg_datapath.sv */
// ----------------------------------------------------------------------------
// Battery voltage gauge datapath
// Configuration registers, sample accumulator, reciprocal multipliers for the
// constant divisions, shared restoring divider and the result register.
// ----------------------------------------------------------------------------
module bvg_datapath #(
    parameter int SAMPLES = bvg_pkg::SAMPLES_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [bvg_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [bvg_pkg::RES_W-1:0]     i_cfg_data,
    input  logic [bvg_pkg::SAMPLE_W-1:0]  i_raw_sample,
    input  bvg_pkg::t_dp_cmd              i_cmd,
    output bvg_pkg::t_dp_status           o_status,
    output logic [bvg_pkg::MV_W-1:0]      o_battery_mv,
    output logic [bvg_pkg::PCT_W-1:0]     o_charge_percent,
    output logic                          o_voltage_saturated
);

    localparam int SUM_W      = bvg_pkg::SAMPLE_W + $clog2(SAMPLES);
    localparam int PIN_PROD_W = 2 * bvg_pkg::SAMPLE_W;
    localparam int SC_PROD_W  = bvg_pkg::SAMPLE_W + bvg_pkg::DEN_W;
    localparam int PCT_PROD_W = bvg_pkg::MV_W + bvg_pkg::PCT_W;
    localparam int AVG_SH     = SUM_W + $clog2(SAMPLES);
    localparam int AVG_MUL_W  = SUM_W + 2;
    localparam int AVG_PROD_W = SUM_W + AVG_MUL_W;
    localparam int PIN_Q_W    = bvg_pkg::PIN_NUM_W + bvg_pkg::PIN_MUL_W;

    // Rounded-up reciprocal of SAMPLES; its error is small enough that the
    // shifted product is the exact floor for every sum that fits SUM_W bits.
    localparam logic [AVG_MUL_W-1:0] AVG_MUL =
        AVG_MUL_W'(((64'd1 << AVG_SH) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

    logic [bvg_pkg::RES_W-1:0] r_upper_r;
    logic [bvg_pkg::RES_W-1:0] r_lower_r;
    logic [bvg_pkg::MV_W-1:0]  r_full_mv;
    logic [bvg_pkg::MV_W-1:0]  r_empty_mv;
    logic [SUM_W-1:0]          r_sum;

    logic [bvg_pkg::DIV_N-1:0] r_quot;
    logic [bvg_pkg::DEN_W-1:0] r_rem;
    logic [bvg_pkg::DEN_W-1:0] r_den;
    logic [bvg_pkg::MV_W-1:0]  r_v;
    logic                      r_sat;
    logic [bvg_pkg::MV_W-1:0]  r_out_mv;
    logic [bvg_pkg::PCT_W-1:0] r_out_pct;
    logic                      r_out_sat;

    logic [SUM_W-1:0]          sum_next;
    logic [bvg_pkg::DEN_W:0]   rem_sh;
    logic [bvg_pkg::DEN_W:0]   rem_diff;
    logic                      rem_ge;
    logic [AVG_PROD_W-1:0]     avg_prod;
    logic [PIN_PROD_W-1:0]     pin_prod;
    logic [PIN_Q_W-1:0]        pin_q_prod;
    logic [SC_PROD_W-1:0]      sc_prod;
    logic [PCT_PROD_W-1:0]     pct_prod;
    logic                      at_full;
    logic                      at_empty;
    logic                      v_over;

    assign sum_next = r_sum + SUM_W'(i_raw_sample);

    // One quotient bit per cycle.
    assign rem_sh   = {r_rem, r_quot[bvg_pkg::DIV_N-1]};
    assign rem_diff = rem_sh - {1'b0, r_den};
    assign rem_ge   = (rem_sh >= {1'b0, r_den});

    // Each step below uses one multiplier and works on the registered value
    // left by the step before.
    assign avg_prod   = AVG_PROD_W'(r_quot[SUM_W-1:0]) * AVG_PROD_W'(AVG_MUL);
    assign pin_prod   = PIN_PROD_W'(r_quot[bvg_pkg::SAMPLE_W-1:0])
                      * PIN_PROD_W'(bvg_pkg::ADC_FULL_SCALE_MV);
    assign pin_q_prod = PIN_Q_W'(r_quot[bvg_pkg::PIN_NUM_W-1:0]) * PIN_Q_W'(bvg_pkg::PIN_MUL);
    assign sc_prod    = SC_PROD_W'(r_quot[bvg_pkg::SAMPLE_W-1:0]) * SC_PROD_W'(r_den);
    assign pct_prod   = PCT_PROD_W'(r_v - r_empty_mv) * PCT_PROD_W'(bvg_pkg::PCT_FULL);

    assign at_full  = (r_v >= r_full_mv);
    assign at_empty = (r_v <= r_empty_mv);
    assign v_over   = |r_quot[bvg_pkg::DIV_N-1:bvg_pkg::MV_W];

    assign o_status.pct_trivial = at_full || at_empty;

    // Configuration and accumulator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper_r  <= bvg_pkg::UPPER_R_RESET;
            r_lower_r  <= bvg_pkg::LOWER_R_RESET;
            r_full_mv  <= bvg_pkg::FULL_MV_RESET;
            r_empty_mv <= bvg_pkg::EMPTY_MV_RESET;
            r_sum      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (bvg_pkg::t_cfg_reg'(i_cfg_index))
                    bvg_pkg::REG_UPPER_R:  r_upper_r  <= i_cfg_data;
                    bvg_pkg::REG_LOWER_R:  r_lower_r  <= i_cfg_data;
                    bvg_pkg::REG_FULL_MV:  r_full_mv  <= i_cfg_data[bvg_pkg::MV_W-1:0];
                    bvg_pkg::REG_EMPTY_MV: r_empty_mv <= i_cfg_data[bvg_pkg::MV_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.op == bvg_pkg::OP_ACCUM) begin
                r_sum <= sum_next;
            end else if (i_cmd.op == bvg_pkg::OP_LAST) begin
                r_sum <= '0;
            end
        end
    end

    // Conversion steps, divider and result payload.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            bvg_pkg::OP_LAST: begin
                r_quot <= bvg_pkg::DIV_N'(sum_next);
            end
            bvg_pkg::OP_AVG: begin
                r_quot <= bvg_pkg::DIV_N'(avg_prod[AVG_SH +: bvg_pkg::SAMPLE_W]);
            end
            bvg_pkg::OP_DIV: begin
                r_quot <= {r_quot[bvg_pkg::DIV_N-2:0], rem_ge};
                r_rem  <= rem_ge ? rem_diff[bvg_pkg::DEN_W-1:0] : rem_sh[bvg_pkg::DEN_W-1:0];
            end
            bvg_pkg::OP_LOAD_PIN: begin
                r_quot <= bvg_pkg::DIV_N'(pin_prod);
            end
            bvg_pkg::OP_PIN: begin
                r_quot <= bvg_pkg::DIV_N'(pin_q_prod[bvg_pkg::PIN_SH +: bvg_pkg::SAMPLE_W]);
            end
            bvg_pkg::OP_RSUM: begin
                r_den <= bvg_pkg::DEN_W'(r_upper_r) + bvg_pkg::DEN_W'(r_lower_r);
            end
            bvg_pkg::OP_LOAD_SCALE: begin
                r_quot <= bvg_pkg::DIV_N'(sc_prod);
                r_den  <= bvg_pkg::DEN_W'(r_lower_r);
                r_rem  <= '0;
            end
            bvg_pkg::OP_VOLT: begin
                if ((r_lower_r == '0) || v_over) begin
                    r_v   <= bvg_pkg::MV_LIMIT;
                    r_sat <= 1'b1;
                end else begin
                    r_v   <= r_quot[bvg_pkg::MV_W-1:0];
                    r_sat <= 1'b0;
                end
            end
            bvg_pkg::OP_LOAD_PCT: begin
                // Only used when empty < v < full; otherwise ignored.
                r_quot <= bvg_pkg::DIV_N'(pct_prod);
                r_den  <= bvg_pkg::DEN_W'(r_full_mv - r_empty_mv);
                r_rem  <= '0;
            end
            bvg_pkg::OP_PUBLISH: begin
                r_out_mv  <= r_v;
                r_out_sat <= r_sat;
                if (at_full) begin
                    r_out_pct <= bvg_pkg::PCT_FULL;
                end else if (at_empty) begin
                    r_out_pct <= bvg_pkg::PCT_EMPTY;
                end else begin
                    r_out_pct <= r_quot[bvg_pkg::PCT_W-1:0];
                end
            end
            default: ;
        endcase
    end

    assign o_battery_mv        = r_out_mv;
    assign o_charge_percent    = r_out_pct;
    assign o_voltage_saturated = r_out_sat;

endmodule

/* hdl/bvg_controller.sv */
// ----------------------------------------------------------------------------
// Battery voltage gauge controller
// Counts samples and sequences the conversion steps on the shared divider.
// ----------------------------------------------------------------------------
`include "battery_voltage_gauge_defines.svh"

module bvg_controller #(
    parameter int SAMPLES = bvg_pkg::SAMPLES_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    output logic                o_valid,
    input  logic                i_stall,
    output bvg_pkg::t_dp_cmd    o_cmd,
    input  bvg_pkg::t_dp_status i_status
);

    localparam int CNT_W = $clog2(SAMPLES + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_AVG,
        S_LOAD_PIN,
        S_PIN,
        S_RSUM,
        S_LOAD_SC,
        S_SC_DIV,
        S_VOLT,
        S_PCT,
        S_PCT_DIV,
        S_PUBLISH
    } t_state;

    t_state                       r_state;
    t_state                       n_state;
    logic [CNT_W-1:0]             r_count;
    logic [bvg_pkg::DIV_CNT_W-1:0] r_div_cnt;
    logic                         r_out_valid;

    logic in_accept;
    logic last_sample;
    logic div_done;
    logic slot_free;

    assign in_accept   = i_valid && (r_state == S_IDLE);
    assign last_sample = (r_count == CNT_W'(SAMPLES - 1));
    assign div_done    = (r_div_cnt == bvg_pkg::DIV_CNT_W'(bvg_pkg::DIV_N - 1));
    assign slot_free   = !r_out_valid || !i_stall;

    always_comb begin
        o_cmd.op = bvg_pkg::OP_NONE;
        n_state  = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (last_sample) begin
                        o_cmd.op = bvg_pkg::OP_LAST;
                        n_state  = S_AVG;
                    end else begin
                        o_cmd.op = bvg_pkg::OP_ACCUM;
                    end
                end
            end
            S_AVG: begin
                o_cmd.op = bvg_pkg::OP_AVG;
                n_state  = S_LOAD_PIN;
            end
            S_LOAD_PIN: begin
                o_cmd.op = bvg_pkg::OP_LOAD_PIN;
                n_state  = S_PIN;
            end
            S_PIN: begin
                o_cmd.op = bvg_pkg::OP_PIN;
                n_state  = S_RSUM;
            end
            S_RSUM: begin
                o_cmd.op = bvg_pkg::OP_RSUM;
                n_state  = S_LOAD_SC;
            end
            S_LOAD_SC: begin
                o_cmd.op = bvg_pkg::OP_LOAD_SCALE;
                n_state  = S_SC_DIV;
            end
            S_SC_DIV: begin
                o_cmd.op = bvg_pkg::OP_DIV;
                if (div_done) n_state = S_VOLT;
            end
            S_VOLT: begin
                o_cmd.op = bvg_pkg::OP_VOLT;
                n_state  = S_PCT;
            end
            S_PCT: begin
                o_cmd.op = bvg_pkg::OP_LOAD_PCT;
                n_state  = i_status.pct_trivial ? S_PUBLISH : S_PCT_DIV;
            end
            S_PCT_DIV: begin
                o_cmd.op = bvg_pkg::OP_DIV;
                if (div_done) n_state = S_PUBLISH;
            end
            S_PUBLISH: begin
                if (slot_free) begin
                    o_cmd.op = bvg_pkg::OP_PUBLISH;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_accept) begin
                r_count <= last_sample ? '0 : r_count + 1'b1;
            end
            if (o_cmd.op == bvg_pkg::OP_DIV) begin
                r_div_cnt <= div_done ? '0 : r_div_cnt + 1'b1;
            end
            if (o_cmd.op == bvg_pkg::OP_PUBLISH) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    `BVG_ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n, (o_cmd.op == bvg_pkg::OP_PUBLISH) && r_out_valid && i_stall, "result overwritten before it was taken")
    `BVG_ASSERT(a_last_starts_avg, i_clk, i_rst_n, (o_cmd.op == bvg_pkg::OP_LAST) |=> ((r_state == S_AVG) && (r_div_cnt == '0)), "conversion did not start cleanly")
    `BVG_ASSERT(a_pct_div_to_pub, i_clk, i_rst_n, ((r_state == S_PCT_DIV) && div_done) |=> (r_state == S_PUBLISH), "percent division did not finish")
    `BVG_ASSERT_NEVER(a_count_range, i_clk, i_rst_n, r_count > CNT_W'(SAMPLES - 1), "sample count out of range")

endmodule

/* hdl/battery_voltage_gauge.sv */
// ----------------------------------------------------------------------------
// Battery voltage gauge top level
// Samples that do not close a block are taken in one cycle each. The closing sample stalls
// input until its result is published, through the conversion steps and two 40-step
// divisions (one when the voltage is at or beyond a level), plus any time the previous
// result still waits at the output.
// Reset is synchronous and active low: sum, count and output valid clear, registers take
// defaults.
// ----------------------------------------------------------------------------
//
// Overview
//   Raw 12-bit ADC samples are summed. Every SAMPLES transactions the block
//   computes:
//     avg     = sum / SAMPLES
//     pin_mv  = avg * 3300 / 4095
//     v       = pin_mv * (upper + lower) / lower, clamped at 65535 with a flag
//     percent = (v - empty) * 100 / (full - empty), clamped to 0..100
//   The two divisions by constants are reciprocal multiplications. The two
//   divisions by configured values share one bit-serial restoring divider.
//   Each multiplication result is registered before it is used again. A zero
//   lower resistor forces the saturated voltage. When the voltage is at or
//   above the full level, or at or below the empty level, the percent
//   division is skipped.
//
// Throughput
//   One result per SAMPLES input transactions. The result sits in an output
//   register, so sampling resumes while it waits to be taken; a following
//   result waits in the publish step until the register is free.
//
// Configuration
//   Registers are written through a plain write port and should only be
//   written while no conversion is in flight.
//
module battery_voltage_gauge #(
    parameter int SAMPLES = bvg_pkg::SAMPLES_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [bvg_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [bvg_pkg::RES_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [bvg_pkg::SAMPLE_W-1:0]  i_raw_sample,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [bvg_pkg::MV_W-1:0]      o_battery_mv,
    output logic [bvg_pkg::PCT_W-1:0]     o_charge_percent,
    output logic                          o_voltage_saturated
);

    // Command from the sequencer and status back from the datapath.
    bvg_pkg::t_dp_cmd    dp_cmd;
    bvg_pkg::t_dp_status dp_status;

    // The controller owns the handshakes, the sample count, the divider step
    // count and the output valid flag.
    bvg_controller #(
        .SAMPLES (SAMPLES)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_cmd    (dp_cmd),
        .i_status (dp_status)
    );

    // The datapath holds the configuration, the accumulator, the divider and
    // the result payload.
    bvg_datapath #(
        .SAMPLES (SAMPLES)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_raw_sample        (i_raw_sample),
        .i_cmd               (dp_cmd),
        .o_status            (dp_status),
        .o_battery_mv        (o_battery_mv),
        .o_charge_percent    (o_charge_percent),
        .o_voltage_saturated (o_voltage_saturated)
    );

endmodule

/* verif/battery_voltage_gauge_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery voltage gauge testbench
// Feeds raw ADC samples into the gauge under a range of divider and level
// settings, predicts every voltage and charge reading from the programmed
// registers and the samples taken, and compares each reading as it leaves.
// ----------------------------------------------------------------------------
module battery_voltage_gauge_tb;

    localparam int GAUGE_SAMPLES = bvg_pkg::SAMPLES_DEFAULT;
    localparam int MAX_SAMPLE    = 4095;
    localparam int MAX_OHM       = 10000000;
    // Time left after the last reading for any conversion still running.
    localparam int SETTLE_CYCLES = 200;
    // Long output hold-off used to back the gauge up into its input.
    localparam int HOLD_CYCLES   = 1200;
    // Cycles without any transaction before the run is declared hung.
    localparam int HANG_LIMIT    = 10000;

    typedef struct packed {
        logic [bvg_pkg::MV_W-1:0]  mv;
        logic [bvg_pkg::PCT_W-1:0] pct;
        logic                      sat;
    } t_gauge_reading;

    // ------------------------------------------------------------------------
    // Clock, reset and the signals around the gauge. Every input has a known
    // value from time zero.
    // ------------------------------------------------------------------------
    logic                         clk           = 1'b0;
    logic                         rst_n         = 1'b0;
    logic                         cfg_wr_en     = 1'b0;
    logic [bvg_pkg::IDX_W-1:0]    cfg_index     = bvg_pkg::REG_UPPER_R;
    logic [bvg_pkg::RES_W-1:0]    cfg_data      = '0;
    logic                         sample_valid  = 1'b0;
    logic [bvg_pkg::SAMPLE_W-1:0] raw_sample    = '0;
    logic                         reading_stall = 1'b0;
    logic                         sample_stall;
    logic                         reading_valid;
    logic [bvg_pkg::MV_W-1:0]     reading_mv;
    logic [bvg_pkg::PCT_W-1:0]    reading_pct;
    logic                         reading_sat;

    always #4 clk = ~clk;

    battery_voltage_gauge #(
        .SAMPLES(GAUGE_SAMPLES)
    ) u_top (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_wr_en        (cfg_wr_en),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .i_valid            (sample_valid),
        .o_stall            (sample_stall),
        .i_raw_sample       (raw_sample),
        .o_valid            (reading_valid),
        .i_stall            (reading_stall),
        .o_battery_mv       (reading_mv),
        .o_charge_percent   (reading_pct),
        .o_voltage_saturated(reading_sat)
    );

    // ------------------------------------------------------------------------
    // Shadow copy of the gauge: its registers and its running accumulation.
    // The registers only change while the gauge is idle, so the shadow is
    // updated together with the writes.
    // ------------------------------------------------------------------------
    logic [bvg_pkg::RES_W-1:0] upper_ohm  = bvg_pkg::UPPER_R_RESET;
    logic [bvg_pkg::RES_W-1:0] lower_ohm  = bvg_pkg::LOWER_R_RESET;
    logic [bvg_pkg::MV_W-1:0]  full_mv    = bvg_pkg::FULL_MV_RESET;
    logic [bvg_pkg::MV_W-1:0]  empty_mv   = bvg_pkg::EMPTY_MV_RESET;
    logic [19:0]               block_sum  = '0;
    int                        block_fill = 0;

    t_gauge_reading pending_readings[$];

    int  mismatches = 0;
    bit  idle_on    = 1'b1;
    int  hold_asks  = 0;

    // Converts the sum of one full block of samples into the reading that
    // the gauge must publish for it.
    function automatic t_gauge_reading convert_block(logic [19:0] sum);
        logic [31:0]    avg;
        logic [31:0]    pin_mv;
        logic [63:0]    scaled;
        logic [31:0]    volts;
        t_gauge_reading r;
        avg    = 32'(sum) / 32'(GAUGE_SAMPLES);
        pin_mv = (avg * 32'(bvg_pkg::ADC_FULL_SCALE_MV)) / 32'(bvg_pkg::ADC_MAX_CODE);
        r.sat  = 1'b1;
        volts  = 32'(bvg_pkg::MV_LIMIT);
        // A zero lower resistor cannot be scaled through and reads as a
        // saturated voltage; otherwise the divider ratio is applied.
        if (lower_ohm != '0) begin
            scaled = 64'(pin_mv) * (64'(upper_ohm) + 64'(lower_ohm)) / 64'(lower_ohm);
            if (scaled <= 64'(bvg_pkg::MV_LIMIT)) begin
                volts = 32'(scaled);
                r.sat = 1'b0;
            end
        end
        r.mv = volts[bvg_pkg::MV_W-1:0];
        // The full level wins over the empty level when they overlap, and no
        // division is done outside the open span between them.
        if (volts >= 32'(full_mv)) begin
            r.pct = bvg_pkg::PCT_FULL;
        end else if (volts <= 32'(empty_mv)) begin
            r.pct = bvg_pkg::PCT_EMPTY;
        end else begin
            r.pct = bvg_pkg::PCT_W'(((volts - 32'(empty_mv)) * 32'd100)
                                    / (32'(full_mv) - 32'(empty_mv)));
        end
        return r;
    endfunction

    // Adds one accepted sample to the shadow accumulation and queues a
    // reading when it closes a block.
    function automatic void take_sample(logic [bvg_pkg::SAMPLE_W-1:0] s);
        block_sum  = block_sum + 20'(s);
        block_fill = block_fill + 1;
        if (block_fill == GAUGE_SAMPLES) begin
            pending_readings.push_back(convert_block(block_sum));
            block_sum  = '0;
            block_fill = 0;
        end
    endfunction

    function automatic void report_mismatch(string what);
        mismatches = mismatches + 1;
        if (mismatches <= 10) begin
            $display("%0t ns: %s", $time, what);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Sender side. One call moves one sample transaction; it may first drop
    // valid for a random burst. Valid stays high between back to back
    // transactions and is only lowered when a gap or a register write
    // follows.
    // ------------------------------------------------------------------------
    task automatic send_sample(input logic [bvg_pkg::SAMPLE_W-1:0] s);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        sample_valid <= 1'b1;
        raw_sample   <= s;
        do begin
            @(posedge clk);
        end while (sample_stall);
        take_sample(s);
    endtask

    // Sends one block of samples scattered around a level. A spread of zero
    // gives a flat block.
    task automatic send_block(input int level, input int spread);
        int lo;
        int hi;
        lo = (level - spread < 0) ? 0 : level - spread;
        hi = (level + spread > MAX_SAMPLE) ? MAX_SAMPLE : level + spread;
        repeat (GAUGE_SAMPLES) send_sample(bvg_pkg::SAMPLE_W'($urandom_range(hi, lo)));
    endtask

    // Lets every outstanding reading come out, then gives the gauge time to
    // finish any conversion still running.
    task automatic wait_idle();
        sample_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Programs all four registers on consecutive edges once the gauge is idle.
    task automatic program_gauge(input logic [bvg_pkg::RES_W-1:0] upper,
                                 input logic [bvg_pkg::RES_W-1:0] lower,
                                 input logic [bvg_pkg::MV_W-1:0] full,
                                 input logic [bvg_pkg::MV_W-1:0] empty);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= bvg_pkg::REG_UPPER_R;
        cfg_data  <= upper;
        @(posedge clk);
        cfg_index <= bvg_pkg::REG_LOWER_R;
        cfg_data  <= lower;
        @(posedge clk);
        cfg_index <= bvg_pkg::REG_FULL_MV;
        cfg_data  <= bvg_pkg::RES_W'(full);
        @(posedge clk);
        cfg_index <= bvg_pkg::REG_EMPTY_MV;
        cfg_data  <= bvg_pkg::RES_W'(empty);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        upper_ohm = upper;
        lower_ohm = lower;
        full_mv   = full;
        empty_mv  = empty;
    endtask

    // ------------------------------------------------------------------------
    // Receiver side. Stall comes in random bursts while idling is on, and in
    // one long hold-off on request. The counters live in this process only.
    // ------------------------------------------------------------------------
    int hold_seen  = 0;
    int stall_left = 0;

    always @(posedge clk) begin
        if (hold_asks != hold_seen) begin
            hold_seen  = hold_asks;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left    = stall_left - 1;
            reading_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left    = $urandom_range(1, 14) - 1;
            reading_stall <= 1'b1;
        end else begin
            reading_stall <= 1'b0;
        end
    end

    // Every reading transaction is compared with the oldest prediction.
    always @(posedge clk) begin
        t_gauge_reading want;
        if (rst_n && reading_valid && !reading_stall) begin
            if (pending_readings.size() == 0) begin
                report_mismatch($sformatf("reading with none expected: mv %0d pct %0d sat %0b",
                                          reading_mv, reading_pct, reading_sat));
            end else begin
                want = pending_readings.pop_front();
                if (reading_mv !== want.mv) begin
                    report_mismatch($sformatf("battery_mv expected %0d got %0d",
                                              want.mv, reading_mv));
                end
                if (reading_pct !== want.pct) begin
                    report_mismatch($sformatf("charge_percent expected %0d got %0d",
                                              want.pct, reading_pct));
                end
                if (reading_sat !== want.sat) begin
                    report_mismatch($sformatf("voltage_saturated expected %0b got %0b",
                                              want.sat, reading_sat));
                end
            end
        end
    end

    // Hang detection: any sample, reading or register write restarts the count.
    int quiet_cycles = 0;

    always @(posedge clk) begin
        if ((sample_valid && !sample_stall) || (reading_valid && !reading_stall) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= HANG_LIMIT) begin
            $display("battery_voltage_gauge: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Default registers: empty input, full-scale input, and a block that
    // mixes two complementary bit patterns to land inside the charge span.
    task automatic test_sample_extremes();
        int i;
        send_block(0, 0);
        send_block(MAX_SAMPLE, 0);
        for (i = 0; i < GAUGE_SAMPLES; i++) begin
            send_sample((i % 2 == 0) ? 12'hAAA : 12'h555);
        end
    endtask

    // Divider corners: a saturating huge ratio, the same with a zero pin voltage,
    // a zero lower resistor, a zero upper one, equal ones with levels at 65535.
    task automatic test_divider_extremes();
        program_gauge(bvg_pkg::RES_W'(MAX_OHM), 24'd1,
                      bvg_pkg::FULL_MV_RESET, bvg_pkg::EMPTY_MV_RESET);
        send_block(MAX_SAMPLE, 0);
        send_block(0, 0);
        program_gauge(bvg_pkg::UPPER_R_RESET, 24'd0,
                      bvg_pkg::FULL_MV_RESET, bvg_pkg::EMPTY_MV_RESET);
        send_block(2048, 0);
        program_gauge(24'd0, bvg_pkg::RES_W'(MAX_OHM),
                      bvg_pkg::FULL_MV_RESET, bvg_pkg::EMPTY_MV_RESET);
        send_block(MAX_SAMPLE, 0);
        program_gauge(bvg_pkg::RES_W'(MAX_OHM), bvg_pkg::RES_W'(MAX_OHM), 16'd65535, 16'd65535);
        send_block(MAX_SAMPLE, 0);
    endtask

    // Level corners: equal levels hit exactly and just missed, reversed
    // levels, the widest span with a saturated voltage, and both levels zero.
    task automatic test_level_extremes();
        program_gauge(bvg_pkg::UPPER_R_RESET, bvg_pkg::LOWER_R_RESET, 16'd3300, 16'd3300);
        send_block(2048, 0);
        send_block(2047, 0);
        program_gauge(bvg_pkg::UPPER_R_RESET, bvg_pkg::LOWER_R_RESET, 16'd3000, 16'd4200);
        send_block(2048, 0);
        send_block(1500, 0);
        program_gauge(bvg_pkg::RES_W'(MAX_OHM), 24'd1, 16'd65535, 16'd0);
        send_block(MAX_SAMPLE, 0);
        program_gauge(bvg_pkg::UPPER_R_RESET, bvg_pkg::LOWER_R_RESET, 16'd0, 16'd0);
        send_block(0, 0);
    endtask

    // The receiver holds off for a long stretch while samples keep coming:
    // one reading parks in the output register, the next waits to publish,
    // and the gauge has to stall its input until the hold-off ends.
    task automatic test_output_hold_off();
        program_gauge(bvg_pkg::UPPER_R_RESET, bvg_pkg::LOWER_R_RESET,
                      bvg_pkg::FULL_MV_RESET, bvg_pkg::EMPTY_MV_RESET);
        hold_asks = hold_asks + 1;
        repeat (4) send_block($urandom_range(MAX_SAMPLE, 0), 64);
    endtask

    // Random phases: each programs a new setting and then streams blocks.
    // Most blocks sit near one level so that the average is meaningful;
    // some are plain noise.
    task automatic test_random_phases();
        int          phase;
        int          blk;
        int          lower;
        int          upper;
        int          empty;
        int          full;
        int          span;
        for (phase = 0; phase < 8; phase++) begin
            case ($urandom_range(0, 7))
                0: begin
                    lower = 0;
                    upper = $urandom_range(MAX_OHM, 0);
                end
                1: begin
                    lower = $urandom_range(1000, 1);
                    upper = $urandom_range(MAX_OHM, 1000000);
                end
                default: begin
                    lower = $urandom_range(MAX_OHM, 1);
                    upper = $urandom_range((lower > MAX_OHM / 3) ? MAX_OHM : 3 * lower, 0);
                end
            endcase
            case ($urandom_range(0, 7))
                0: begin
                    full  = $urandom_range(65535, 0);
                    empty = $urandom_range(65535, full);
                end
                1: begin
                    full  = 65535;
                    empty = 0;
                end
                default: begin
                    empty = $urandom_range(9000, 0);
                    full  = empty + $urandom_range(4000, 1);
                end
            endcase
            program_gauge(bvg_pkg::RES_W'(upper), bvg_pkg::RES_W'(lower),
                          bvg_pkg::MV_W'(full), bvg_pkg::MV_W'(empty));
            idle_on = ($urandom_range(0, 3) != 0);
            for (blk = 0; blk < 12; blk++) begin
                span = ($urandom_range(0, 4) == 0) ? MAX_SAMPLE : $urandom_range(40, 0);
                send_block($urandom_range(MAX_SAMPLE, 0), span);
            end
        end
        idle_on = 1'b1;
    endtask

    // Closing stretch with no idling on either side.
    task automatic test_steady_stream();
        program_gauge(bvg_pkg::UPPER_R_RESET, bvg_pkg::LOWER_R_RESET,
                      bvg_pkg::FULL_MV_RESET, bvg_pkg::EMPTY_MV_RESET);
        idle_on = 1'b0;
        repeat (10) send_block($urandom_range(2700, 1700), 20);
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_sample_extremes();
        test_divider_extremes();
        test_level_extremes();
        test_output_hold_off();
        test_random_phases();
        test_steady_stream();
        wait_idle();
        if (mismatches == 0) begin
            $display("battery_voltage_gauge: match");
        end else begin
            $display("battery_voltage_gauge: mismatch");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/bvg_pkg.sv
hdl/bvg_datapath.sv
hdl/bvg_controller.sv
hdl/battery_voltage_gauge.sv
verif/battery_voltage_gauge_tb.sv
